// ===== sv/rcs_pkg.sv =====
// Shared types and constants for the polyline clipper and viewport mapper.
package rcs_pkg;

    localparam int COORD_W = 32;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int SPAN_W  = 13;
    localparam int PIX_W   = 16;
    localparam int CFG_AW  = 3;

    typedef enum logic [CFG_AW-1:0] {
        CFG_X_LOW       = 3'd0,
        CFG_X_HIGH      = 3'd1,
        CFG_Y_LOW       = 3'd2,
        CFG_Y_HIGH      = 3'd3,
        CFG_PLOT_WIDTH  = 3'd4,
        CFG_PLOT_HEIGHT = 3'd5
    } cfg_idx_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LATCH,
        DP_SETUP_PEND,
        DP_ADVANCE,
        DP_SETUP_FIN,
        DP_LOAD_QP,
        DP_LOAD_PQ,
        DP_LOAD_PN,
        DP_MUL,
        DP_DIV_START,
        DP_WB,
        DP_PUSH_VTX,
        DP_PUSH_MARK,
        DP_FLUSH
    } dp_op_t;

    typedef enum logic [1:0] {
        AR_CLIPX,
        AR_CLIPY,
        AR_PIXX,
        AR_PIXY
    } ar_op_t;

    typedef struct packed {
        dp_op_t op;
        ar_op_t ar;
        logic   esel_c;
    } cmd_t;

    typedef struct packed {
        logic in_p;
        logic in_q;
        logic in_n;
        logic hp;
        logic hn;
        logic pend_valid;
        logic fin;
        logic cx_out;
        logic cy_out;
        logic div_done;
        logic hold_valid;
        logic out_free;
        logic push_ok;
    } stat_t;

endpackage

// ===== sv/rcs_divider.sv =====
// Restoring serial divider, one quotient bit per cycle.
module rcs_divider
    import rcs_pkg::*;
#(
    parameter int N_W = 66,
    parameter int D_W = 33
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [N_W-1:0] dividend,
    input  logic [D_W-1:0] divisor,
    output logic [N_W-1:0] quotient,
    output logic           busy,
    output logic           done
);

    localparam int CNT_W = $clog2(N_W + 1);

    logic [N_W-1:0]   quo_reg, quo_next;
    logic [D_W-1:0]   rem_reg, rem_next;
    logic [D_W-1:0]   dvs_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [D_W:0]     sh;
    logic [D_W:0]     diff;
    logic             take;

    always_comb begin
        sh   = {rem_reg, quo_reg[N_W-1]};
        diff = sh - {1'b0, dvs_reg};
        take = (sh >= {1'b0, dvs_reg});
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next = dividend;
            rem_next = '0;
            cnt_next = CNT_W'(N_W);
        end else if (cnt_reg != '0) begin
            quo_next = {quo_reg[N_W-2:0], take};
            rem_next = take ? diff[D_W-1:0] : sh[D_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start) dvs_reg <= divisor;
    end

    assign quotient = quo_reg;
    assign busy     = (cnt_reg != '0);
    assign done     = done_reg;

endmodule

// ===== sv/rcs_datapath.sv =====
// Datapath: point history, clip and pixel arithmetic, vertex hold and output register.
module rcs_datapath
    import rcs_pkg::*;
#(
    parameter int EDGE_OFFSET = 75
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cmd_t                 cmd,
    output stat_t                stat,
    input  logic                 cfg_wr_en,
    input  logic [CFG_AW-1:0]    cfg_addr,
    input  logic [COORD_W-1:0]   cfg_wdata,
    input  logic [2*COORD_W-1:0] s_tdata,
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [2*PIX_W-1:0]   m_tdata,
    output logic                 m_tlast,
    output logic                 m_tuser
);

    localparam int OFS_W  = $clog2(EDGE_OFFSET + 2) + 1;
    localparam int T1_W   = DIFF_W + SPAN_W + 1;
    localparam int T2_W   = DIFF_W + OFS_W;
    localparam int NUM_W  = ((T1_W > T2_W) ? T1_W : T2_W) + 1;
    localparam int PMAX   = (1 << (PIX_W - 1)) - 1;

    typedef logic signed [COORD_W-1:0] crd_t;

    crd_t xl_reg, xh_reg, yl_reg, yh_reg;
    logic [SPAN_W-1:0] pw_reg, ph_reg;

    crd_t cur_x_reg, cur_y_reg, pri_x_reg, pri_y_reg, pen_x_reg, pen_y_reg;
    logic fin_reg, pri_v_reg, pen_v_reg;
    crd_t p_x_reg, p_y_reg, q_x_reg, q_y_reg, n_x_reg, n_y_reg;
    logic hp_reg, hn_reg;
    crd_t a_x_reg, a_y_reg, b_x_reg, b_y_reg, c_x_reg, c_y_reg;

    logic [PROD_W-1:0] dvd_reg;
    logic [DIFF_W-1:0] dvs_reg, cap_reg;
    logic              neg_reg, dz_reg;
    crd_t              base_reg, bnd_reg;

    logic [PIX_W-1:0] px_reg, py_reg;
    logic [PIX_W-1:0] hx_reg, hy_reg;
    logic             hvtx_reg, hv_reg;
    logic [PIX_W-1:0] ox_reg, oy_reg;
    logic             ovtx_reg, olast_reg, ov_reg;

    logic [PROD_W-1:0] quo;
    logic              div_busy, div_done;

    function automatic logic is_in(crd_t x, crd_t y, crd_t xl, crd_t xh, crd_t yl, crd_t yh);
        return (x >= xl) && (x <= xh) && (y >= yl) && (y <= yh);
    endfunction

    function automatic logic signed [DIFF_W-1:0] sub33(crd_t u, crd_t v);
        return {u[COORD_W-1], u} - {v[COORD_W-1], v};
    endfunction

    function automatic logic [DIFF_W-1:0] mag33(logic signed [DIFF_W-1:0] v);
        return v[DIFF_W-1] ? -v : v;
    endfunction

    // operand formation for the shared multiply-divide
    logic signed [DIFF_W-1:0] dn, mm, dd, den, dv;
    logic signed [T1_W-1:0]   t1;
    logic signed [T2_W-1:0]   t2;
    logic signed [NUM_W-1:0]  num;
    logic [NUM_W-1:0]         num_mag;
    logic signed [SPAN_W:0]   span_s;
    logic signed [OFS_W-1:0]  ofs_s;
    crd_t                     e_x, e_y, bnd, v, lo, hi;
    logic                     cx_lo, cx_hi, cy_lo, cy_hi;

    assign cx_lo = (c_x_reg < xl_reg);
    assign cx_hi = (c_x_reg > xh_reg);
    assign cy_lo = (c_y_reg < yl_reg);
    assign cy_hi = (c_y_reg > yh_reg);
    assign ofs_s = OFS_W'(EDGE_OFFSET);

    always_comb begin
        e_x = cmd.esel_c ? c_x_reg : p_x_reg;
        e_y = cmd.esel_c ? c_y_reg : p_y_reg;
        if (cmd.ar == AR_CLIPX) begin
            bnd = cx_lo ? xl_reg : xh_reg;
            dn  = sub33(bnd, b_x_reg);
            mm  = sub33(a_y_reg, b_y_reg);
            dd  = sub33(a_x_reg, b_x_reg);
        end else begin
            bnd = cy_lo ? yl_reg : yh_reg;
            dn  = sub33(bnd, b_y_reg);
            mm  = sub33(a_x_reg, b_x_reg);
            dd  = sub33(a_y_reg, b_y_reg);
        end
        if (cmd.ar == AR_PIXX) begin
            v = e_x; lo = xl_reg; hi = xh_reg; span_s = $signed({1'b0, pw_reg});
        end else begin
            v = e_y; lo = yl_reg; hi = yh_reg; span_s = $signed({1'b0, ph_reg});
        end
        den     = sub33(hi, lo);
        dv      = sub33(v, lo);
        t1      = dv * span_s;
        t2      = den * ofs_s;
        num     = NUM_W'(t1) + NUM_W'(t2);
        num_mag = num[NUM_W-1] ? -num : num;
    end

    // write-back arithmetic
    logic [DIFF_W-1:0]        qs;
    logic signed [DIFF_W:0]   res;
    logic [PIX_W-1:0]         pix;

    always_comb begin
        qs  = (quo > PROD_W'(cap_reg)) ? cap_reg : quo[DIFF_W-1:0];
        res = {{2{base_reg[COORD_W-1]}}, base_reg};
        if (!dz_reg && qs != '0) begin
            res = neg_reg ? res - $signed({1'b0, qs}) : res + $signed({1'b0, qs});
        end
        if (dz_reg) begin
            pix = PIX_W'(EDGE_OFFSET);
        end else if (!neg_reg) begin
            pix = (quo > PROD_W'(PMAX)) ? PIX_W'(PMAX) : quo[PIX_W-1:0];
        end else begin
            pix = (quo > PROD_W'(PMAX + 1)) ? {1'b1, {(PIX_W-1){1'b0}}}
                                             : (~quo[PIX_W-1:0]) + 1'b1;
        end
    end

    logic out_free, push_ok, out_load;
    assign out_free = !ov_reg || m_tready;
    assign push_ok  = !hv_reg || out_free;
    assign out_load = ((cmd.op == DP_PUSH_VTX || cmd.op == DP_PUSH_MARK) && hv_reg)
                      || (cmd.op == DP_FLUSH);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            xl_reg    <= '0;
            xh_reg    <= 32'sd65536;
            yl_reg    <= '0;
            yh_reg    <= 32'sd65536;
            pw_reg    <= SPAN_W'(512);
            ph_reg    <= SPAN_W'(512);
            pri_v_reg <= 1'b0;
            pen_v_reg <= 1'b0;
            pri_x_reg <= '0;
            pri_y_reg <= '0;
            pen_x_reg <= '0;
            pen_y_reg <= '0;
            hv_reg    <= 1'b0;
            ov_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_X_LOW:       xl_reg <= cfg_wdata;
                    CFG_X_HIGH:      xh_reg <= cfg_wdata;
                    CFG_Y_LOW:       yl_reg <= cfg_wdata;
                    CFG_Y_HIGH:      yh_reg <= cfg_wdata;
                    CFG_PLOT_WIDTH:  pw_reg <= cfg_wdata[SPAN_W-1:0];
                    CFG_PLOT_HEIGHT: ph_reg <= cfg_wdata[SPAN_W-1:0];
                    default: ;
                endcase
            end
            if (out_load) ov_reg <= 1'b1;
            else if (ov_reg && m_tready) ov_reg <= 1'b0;
            unique case (cmd.op)
                DP_ADVANCE: begin
                    if (pen_v_reg) begin
                        pri_x_reg <= pen_x_reg;
                        pri_y_reg <= pen_y_reg;
                        pri_v_reg <= 1'b1;
                    end
                    pen_x_reg <= cur_x_reg;
                    pen_y_reg <= cur_y_reg;
                    pen_v_reg <= 1'b1;
                end
                DP_PUSH_VTX, DP_PUSH_MARK: begin
                    if (hv_reg) begin
                        ox_reg    <= hx_reg;
                        oy_reg    <= hy_reg;
                        ovtx_reg  <= hvtx_reg;
                        olast_reg <= 1'b0;
                    end
                    hv_reg <= 1'b1;
                    if (cmd.op == DP_PUSH_VTX) begin
                        hx_reg   <= px_reg;
                        hy_reg   <= py_reg;
                        hvtx_reg <= 1'b1;
                    end else begin
                        hx_reg    <= '0;
                        hy_reg    <= '0;
                        hvtx_reg  <= 1'b0;
                        pri_v_reg <= 1'b0;
                        pen_v_reg <= 1'b0;
                    end
                end
                DP_FLUSH: begin
                    ox_reg    <= hx_reg;
                    oy_reg    <= hy_reg;
                    ovtx_reg  <= hvtx_reg;
                    olast_reg <= 1'b1;
                    hv_reg    <= 1'b0;
                end
                default: ;
            endcase
        end

        unique case (cmd.op)
            DP_LATCH: begin
                cur_x_reg <= s_tdata[COORD_W-1:0];
                cur_y_reg <= s_tdata[2*COORD_W-1:COORD_W];
                fin_reg   <= s_tlast;
            end
            DP_SETUP_PEND: begin
                p_x_reg <= pen_x_reg; p_y_reg <= pen_y_reg;
                q_x_reg <= pri_x_reg; q_y_reg <= pri_y_reg;
                n_x_reg <= cur_x_reg; n_y_reg <= cur_y_reg;
                hp_reg  <= pri_v_reg;
                hn_reg  <= 1'b1;
            end
            DP_SETUP_FIN: begin
                p_x_reg <= cur_x_reg; p_y_reg <= cur_y_reg;
                q_x_reg <= pri_x_reg; q_y_reg <= pri_y_reg;
                hp_reg  <= pri_v_reg;
                hn_reg  <= 1'b0;
            end
            DP_LOAD_QP: begin
                a_x_reg <= q_x_reg; a_y_reg <= q_y_reg;
                c_x_reg <= q_x_reg; c_y_reg <= q_y_reg;
                b_x_reg <= p_x_reg; b_y_reg <= p_y_reg;
            end
            DP_LOAD_PQ: begin
                a_x_reg <= p_x_reg; a_y_reg <= p_y_reg;
                c_x_reg <= p_x_reg; c_y_reg <= p_y_reg;
                b_x_reg <= q_x_reg; b_y_reg <= q_y_reg;
            end
            DP_LOAD_PN: begin
                a_x_reg <= p_x_reg; a_y_reg <= p_y_reg;
                c_x_reg <= p_x_reg; c_y_reg <= p_y_reg;
                b_x_reg <= n_x_reg; b_y_reg <= n_y_reg;
            end
            DP_MUL: begin
                bnd_reg <= bnd;
                if (cmd.ar == AR_CLIPX || cmd.ar == AR_CLIPY) begin
                    dvd_reg  <= mag33(dn) * mag33(mm);
                    dvs_reg  <= mag33(dd);
                    cap_reg  <= mag33(mm);
                    neg_reg  <= dn[DIFF_W-1] ^ mm[DIFF_W-1] ^ dd[DIFF_W-1];
                    dz_reg   <= (dd == '0);
                    base_reg <= (cmd.ar == AR_CLIPX) ? b_y_reg : b_x_reg;
                end else begin
                    dvd_reg <= PROD_W'(num_mag);
                    dvs_reg <= mag33(den);
                    neg_reg <= num[NUM_W-1] ^ den[DIFF_W-1];
                    dz_reg  <= (den == '0);
                end
            end
            DP_WB: begin
                unique case (cmd.ar)
                    AR_CLIPX: begin c_x_reg <= bnd_reg; c_y_reg <= res[COORD_W-1:0]; end
                    AR_CLIPY: begin c_y_reg <= bnd_reg; c_x_reg <= res[COORD_W-1:0]; end
                    AR_PIXX:  px_reg <= pix;
                    AR_PIXY:  py_reg <= pix;
                endcase
            end
            default: ;
        endcase
    end

    rcs_divider #(
        .N_W (PROD_W),
        .D_W (DIFF_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.op == DP_DIV_START),
        .dividend (dvd_reg),
        .divisor  (dvs_reg),
        .quotient (quo),
        .busy     (div_busy),
        .done     (div_done)
    );

    always_comb begin
        stat.in_p       = is_in(p_x_reg, p_y_reg, xl_reg, xh_reg, yl_reg, yh_reg);
        stat.in_q       = is_in(q_x_reg, q_y_reg, xl_reg, xh_reg, yl_reg, yh_reg);
        stat.in_n       = is_in(n_x_reg, n_y_reg, xl_reg, xh_reg, yl_reg, yh_reg);
        stat.hp         = hp_reg;
        stat.hn         = hn_reg;
        stat.pend_valid = pen_v_reg;
        stat.fin        = fin_reg;
        stat.cx_out     = cx_lo || cx_hi;
        stat.cy_out     = cy_lo || cy_hi;
        stat.div_done   = div_done;
        stat.hold_valid = hv_reg;
        stat.out_free   = out_free;
        stat.push_ok    = push_ok;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {oy_reg, ox_reg};
    assign m_tlast  = olast_reg;
    assign m_tuser  = ovtx_reg;

    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == DP_DIV_START) |-> !div_busy)
        else $error("divider started while busy");
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        ((cmd.op == DP_PUSH_VTX || cmd.op == DP_PUSH_MARK) && hv_reg) |-> out_free)
        else $error("held vertex pushed into a full output register");
    a_flush_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == DP_FLUSH) |-> (hv_reg && out_free))
        else $error("flush without a held result or room");
    a_wb_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == DP_WB) |-> !div_busy)
        else $error("write-back before the division finished");

endmodule

// ===== sv/rcs_ctrl.sv =====
// Controller: sequences judging, clipping, pixel mapping and result hand-off per point.
module rcs_ctrl
    import rcs_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_CHK, S_JUDGE, S_CLIP_X, S_CLIP_Y, S_MUL, S_DIV, S_WAIT,
        S_WB, S_PUSH, S_ADV, S_SETUP_FIN, S_MARK, S_FLUSH
    } state_t;

    state_t state_reg;
    ar_op_t ar_reg;
    logic   esel_reg, emit_p_reg, ret_fin_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            ar_reg      <= AR_PIXX;
            esel_reg    <= 1'b0;
            emit_p_reg  <= 1'b0;
            ret_fin_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: if (s_tvalid) state_reg <= S_CHK;
                S_CHK: begin
                    ret_fin_reg <= 1'b0;
                    state_reg   <= stat.pend_valid ? S_JUDGE : S_ADV;
                end
                S_JUDGE: begin
                    priority if (stat.in_p && stat.hp && !stat.in_q) begin
                        emit_p_reg <= 1'b1;
                        state_reg  <= S_CLIP_X;
                    end else if (stat.in_p) begin
                        emit_p_reg <= 1'b0;
                        esel_reg   <= 1'b0;
                        ar_reg     <= AR_PIXX;
                        state_reg  <= S_MUL;
                    end else if ((stat.hp && stat.in_q) || (stat.hn && stat.in_n)) begin
                        emit_p_reg <= 1'b0;
                        state_reg  <= S_CLIP_X;
                    end else begin
                        state_reg <= ret_fin_reg ? S_MARK : S_ADV;
                    end
                end
                S_CLIP_X: begin
                    if (stat.cx_out) begin
                        ar_reg    <= AR_CLIPX;
                        state_reg <= S_MUL;
                    end else begin
                        state_reg <= S_CLIP_Y;
                    end
                end
                S_CLIP_Y: begin
                    ar_reg    <= stat.cy_out ? AR_CLIPY : AR_PIXX;
                    esel_reg  <= 1'b1;
                    state_reg <= S_MUL;
                end
                S_MUL:  state_reg <= S_DIV;
                S_DIV:  state_reg <= S_WAIT;
                S_WAIT: if (stat.div_done) state_reg <= S_WB;
                S_WB: begin
                    unique case (ar_reg)
                        AR_CLIPX: state_reg <= S_CLIP_Y;
                        AR_CLIPY: begin
                            ar_reg    <= AR_PIXX;
                            state_reg <= S_MUL;
                        end
                        AR_PIXX: begin
                            ar_reg    <= AR_PIXY;
                            state_reg <= S_MUL;
                        end
                        AR_PIXY: state_reg <= S_PUSH;
                    endcase
                end
                S_PUSH: begin
                    if (stat.push_ok) begin
                        if (esel_reg && emit_p_reg) begin
                            esel_reg   <= 1'b0;
                            emit_p_reg <= 1'b0;
                            ar_reg     <= AR_PIXX;
                            state_reg  <= S_MUL;
                        end else begin
                            state_reg <= ret_fin_reg ? S_MARK : S_ADV;
                        end
                    end
                end
                S_ADV: state_reg <= stat.fin ? S_SETUP_FIN : S_FLUSH;
                S_SETUP_FIN: begin
                    ret_fin_reg <= 1'b1;
                    state_reg   <= S_JUDGE;
                end
                S_MARK: if (stat.push_ok) state_reg <= S_FLUSH;
                S_FLUSH: if (!stat.hold_valid || stat.out_free) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        cmd.op     = DP_NOP;
        cmd.ar     = ar_reg;
        cmd.esel_c = esel_reg;
        unique case (state_reg)
            S_IDLE: if (s_tvalid) cmd.op = DP_LATCH;
            S_CHK:  if (stat.pend_valid) cmd.op = DP_SETUP_PEND;
            S_JUDGE: begin
                priority if (stat.in_p && stat.hp && !stat.in_q) cmd.op = DP_LOAD_QP;
                else if (stat.in_p) cmd.op = DP_NOP;
                else if (stat.hp && stat.in_q) cmd.op = DP_LOAD_PQ;
                else if (stat.hn && stat.in_n) cmd.op = DP_LOAD_PN;
                else cmd.op = DP_NOP;
            end
            S_MUL:       cmd.op = DP_MUL;
            S_DIV:       cmd.op = DP_DIV_START;
            S_WB:        cmd.op = DP_WB;
            S_PUSH:      if (stat.push_ok) cmd.op = DP_PUSH_VTX;
            S_ADV:       cmd.op = DP_ADVANCE;
            S_SETUP_FIN: cmd.op = DP_SETUP_FIN;
            S_MARK:      if (stat.push_ok) cmd.op = DP_PUSH_MARK;
            S_FLUSH:     if (stat.hold_valid && stat.out_free) cmd.op = DP_FLUSH;
            default:     cmd.op = DP_NOP;
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule

// ===== sv/polyline_rect_clip_to_screen.sv =====
// Top level: polyline clipper to an axis box with mapping of vertices to screen pixels.
// One point is taken at a time; s_tready is high only between points. Each point is sequenced
// through the shared serial divider (one quotient bit per cycle over a 66-bit dividend), which
// runs two divisions per emitted vertex for the pixel mapping and up to two more per clipped
// crossing. Results pass through a one-deep hold stage and an output register, so the next
// point is taken while the last result of the previous one waits on m_tready.
module polyline_rect_clip_to_screen
    import rcs_pkg::*;
#(
    parameter int EDGE_OFFSET = 75
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_AW-1:0]    cfg_addr,
    input  logic [COORD_W-1:0]   cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [2*COORD_W-1:0] s_tdata,   // pt_x, pt_y
    input  logic                 s_tlast,   // final_point
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [2*PIX_W-1:0]   m_tdata,   // screen_x, screen_y
    output logic                 m_tlast,   // run_last
    output logic                 m_tuser    // is_vertex
);

    cmd_t  cmd;
    stat_t stat;

    rcs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rcs_datapath #(
        .EDGE_OFFSET (EDGE_OFFSET)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== tb/sv/tb.sv =====
// Testbench for the polyline clipper: directed and random curves against a built-in predictor.
`timescale 1ns / 100ps
module tb;
    import rcs_pkg::*;

    localparam longint EDGE_PX = 75;
    localparam int LIMIT = 4000000;
    localparam int SETTLE = 1200;

    typedef struct { longint x; longint y; } point_t;
    typedef struct { logic [31:0] x; logic [31:0] y; logic fin; } pt_item_t;
    typedef struct { logic [15:0] sx; logic [15:0] sy; logic vtx; logic last; } vertex_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_AW-1:0] cfg_addr = '0;
    logic [COORD_W-1:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [2*COORD_W-1:0] s_tdata = '0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [2*PIX_W-1:0] m_tdata;
    logic m_tlast;
    logic m_tuser;

    polyline_rect_clip_to_screen u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .m_tuser(m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // predictor copy of registers and point history
    longint bx_lo = 0, bx_hi = 65536, by_lo = 0, by_hi = 65536;
    longint span_w = 512, span_h = 512;
    longint pr_x = 0, pr_y = 0, pd_x = 0, pd_y = 0;
    bit pr_v = 0, pd_v = 0;

    pt_item_t point_q[$];
    vertex_t vertex_q[$];
    vertex_t step_q[$];

    int err_cnt = 0;
    int n_points = 0, n_vertices = 0, n_markers = 0, n_settings = 0;
    int snd_idle = 37, rcv_idle = 60;
    int hold_req = 0, hold_done = 0, hold_cnt = 0;
    int cycles = 0;
    bit in_acc = 0;

    task automatic report_err(string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        err_cnt++;
    endtask

    function automatic bit in_box(point_t p);
        return p.x >= bx_lo && p.x <= bx_hi && p.y >= by_lo && p.y <= by_hi;
    endfunction

    function automatic longint cross_at(longint base, longint dn, longint m, longint d);
        logic [63:0] a, b, c;
        logic [127:0] q;
        bit neg;
        a = dn < 0 ? -dn : dn;
        b = m < 0 ? -m : m;
        c = d < 0 ? -d : d;
        if (d == 0) return base;
        q = {64'd0, a} * {64'd0, b};
        q = q / {64'd0, c};
        if (q > {64'd0, b}) q = {64'd0, b};
        if (q == 0) return base;
        neg = ((dn < 0) != (m < 0)) != (d < 0);
        return neg ? base - longint'(q[63:0]) : base + longint'(q[63:0]);
    endfunction

    // outside point a pulled onto the box edge toward inside anchor b
    function automatic point_t clip_toward(point_t a, point_t b);
        point_t c;
        c = a;
        if (c.x < bx_lo) begin
            c.x = bx_lo;
            c.y = cross_at(b.y, bx_lo - b.x, a.y - b.y, a.x - b.x);
        end else if (c.x > bx_hi) begin
            c.x = bx_hi;
            c.y = cross_at(b.y, bx_hi - b.x, a.y - b.y, a.x - b.x);
        end
        if (c.y < by_lo) begin
            c.y = by_lo;
            c.x = cross_at(b.x, by_lo - b.y, a.x - b.x, a.y - b.y);
        end else if (c.y > by_hi) begin
            c.y = by_hi;
            c.x = cross_at(b.x, by_hi - b.y, a.x - b.x, a.y - b.y);
        end
        return c;
    endfunction

    function automatic logic [15:0] pixel(longint v, longint lo, longint hi, longint span);
        longint den, r;
        den = hi - lo;
        if (den == 0) r = EDGE_PX;
        else r = (EDGE_PX * den + (v - lo) * span) / den;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    task automatic push_vertex(point_t p);
        vertex_t v;
        v.sx = pixel(p.x, bx_lo, bx_hi, span_w);
        v.sy = pixel(p.y, by_lo, by_hi, span_h);
        v.vtx = 1'b1;
        v.last = 1'b0;
        step_q.push_back(v);
    endtask

    task automatic judge(point_t p, bit hp, point_t q, bit hn, point_t n);
        if (in_box(p)) begin
            if (hp && !in_box(q)) push_vertex(clip_toward(q, p));
            push_vertex(p);
        end else if (hp && in_box(q)) begin
            push_vertex(clip_toward(p, q));
        end else if (hn && in_box(n)) begin
            push_vertex(clip_toward(p, n));
        end
    endtask

    task automatic predict_point(logic [31:0] x, logic [31:0] y, logic fin);
        point_t cur, pend, prev;
        vertex_t mk;
        step_q = {};
        cur.x = longint'($signed(x));
        cur.y = longint'($signed(y));
        if (pd_v) begin
            pend.x = pd_x; pend.y = pd_y;
            prev.x = pr_x; prev.y = pr_y;
            judge(pend, pr_v, prev, 1'b1, cur);
            pr_x = pd_x; pr_y = pd_y; pr_v = 1'b1;
        end
        pd_x = cur.x; pd_y = cur.y; pd_v = 1'b1;
        if (fin) begin
            prev.x = pr_x; prev.y = pr_y;
            judge(cur, pr_v, prev, 1'b0, cur);
            mk.sx = '0; mk.sy = '0; mk.vtx = 1'b0; mk.last = 1'b0;
            step_q.push_back(mk);
            pr_v = 1'b0;
            pd_v = 1'b0;
        end
        if (step_q.size() > 0) step_q[step_q.size()-1].last = 1'b1;
        foreach (step_q[i]) vertex_q.push_back(step_q[i]);
    endtask

    // input and output transfers, sampled at the rising edge
    always @(posedge aclk) begin
        vertex_t e;
        cycles++;
        in_acc = aresetn && s_tvalid && s_tready;
        if (in_acc) begin
            predict_point(s_tdata[31:0], s_tdata[63:32], s_tlast);
            n_points++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (vertex_q.size() == 0) begin
                report_err($sformatf("unexpected result %h tlast=%b tuser=%b",
                                     m_tdata, m_tlast, m_tuser));
            end else begin
                e = vertex_q.pop_front();
                if (m_tuser) n_vertices++; else n_markers++;
                if (m_tdata[15:0] !== e.sx)
                    report_err($sformatf("screen_x %h, want %h", m_tdata[15:0], e.sx));
                if (m_tdata[31:16] !== e.sy)
                    report_err($sformatf("screen_y %h, want %h", m_tdata[31:16], e.sy));
                if (m_tuser !== e.vtx)
                    report_err($sformatf("is_vertex %b, want %b", m_tuser, e.vtx));
                if (m_tlast !== e.last)
                    report_err($sformatf("run_last %b, want %b", m_tlast, e.last));
            end
        end
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(negedge aclk) begin
        pt_item_t it;
        if (aresetn && (!s_tvalid || in_acc)) begin
            if (point_q.size() > 0 && $urandom_range(0, 99) >= snd_idle) begin
                it = point_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {it.y, it.x};
                s_tlast <= it.fin;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end else if (hold_req != hold_done) begin
            hold_done <= hold_req;
            hold_cnt <= 3000;
            m_tready <= 1'b0;
        end else begin
            m_tready <= aresetn && ($urandom_range(0, 99) >= rcv_idle);
        end
    end

    task automatic add_point(longint x, longint y, bit fin);
        pt_item_t it;
        it.x = x[31:0];
        it.y = y[31:0];
        it.fin = fin;
        point_q.push_back(it);
    endtask

    function automatic longint pick_coord(longint lo, longint hi);
        longint span;
        logic [63:0] r;
        r = {$urandom, $urandom};
        span = hi - lo + 1;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return span > 0 ? lo + longint'(r[62:0]) % span : lo;
            4: return lo - $urandom_range(1, 20000);
            5: return hi + $urandom_range(1, 20000);
            6: return longint'($signed($urandom));
            7: return $urandom_range(0, 1) ? 64'sh7FFFFFFF : -64'sh80000000;
            8: return lo;
            default: return hi;
        endcase
    endfunction

    task automatic add_curve(int n);
        for (int i = 0; i < n; i++)
            add_point(pick_coord(bx_lo, bx_hi), pick_coord(by_lo, by_hi), i == n - 1);
    endtask

    task automatic add_curves(int count);
        int left;
        left = count;
        while (left > 0) begin
            int n;
            n = $urandom_range(1, 8);
            if (n > left) n = left;
            add_curve(n);
            left -= n;
        end
    endtask

    task automatic wait_idle();
        while (point_q.size() > 0 || s_tvalid || vertex_q.size() > 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic drive_reg(cfg_idx_t a, logic [31:0] d);
        cfg_wr_en <= 1'b1;
        cfg_addr <= a;
        cfg_wdata <= d;
        @(negedge aclk);
    endtask

    task automatic apply_cfg(longint xl, longint xh, longint yl, longint yh,
                             longint w, longint h);
        drive_reg(CFG_X_LOW, xl[31:0]);
        drive_reg(CFG_X_HIGH, xh[31:0]);
        drive_reg(CFG_Y_LOW, yl[31:0]);
        drive_reg(CFG_Y_HIGH, yh[31:0]);
        drive_reg(CFG_PLOT_WIDTH, {19'd0, w[12:0]});
        drive_reg(CFG_PLOT_HEIGHT, {19'd0, h[12:0]});
        cfg_wr_en <= 1'b0;
        bx_lo = longint'($signed(xl[31:0]));
        bx_hi = longint'($signed(xh[31:0]));
        by_lo = longint'($signed(yl[31:0]));
        by_hi = longint'($signed(yh[31:0]));
        span_w = w & 13'h1FFF;
        span_h = h & 13'h1FFF;
        n_settings++;
    endtask

    task automatic random_cfg();
        longint xl, yl;
        xl = longint'($signed($urandom_range(0, 32'h3FFFFF))) - 32'h200000;
        yl = longint'($signed($urandom_range(0, 32'h3FFFFF))) - 32'h200000;
        apply_cfg(xl, xl + $urandom_range(1, 32'h1FFFFF),
                  yl, yl + $urandom_range(1, 32'h1FFFFF),
                  $urandom_range(0, 8191), $urandom_range(0, 8191));
    endtask

    task automatic set_mode();
        if (n_points < 160) begin
            snd_idle = 37; rcv_idle = 60;
        end else if (n_points < 320) begin
            snd_idle = 60; rcv_idle = 37;
        end else begin
            snd_idle = 0; rcv_idle = 0;
        end
    endtask

    initial begin
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        n_settings = 1;

        // default box: corners, far extremes, crossings, single-point curves
        add_point(0, 0, 1);
        add_point(65536, 65536, 1);
        add_point(-64'sh80000000, 64'sh7FFFFFFF, 1);
        add_point(32768, 32768, 0);
        add_point(200000, 40000, 0);
        add_point(-100000, 30000, 0);
        add_point(30000, 30000, 0);
        add_point(30000, -90000, 0);
        add_point(64'sh7FFFFFFF, -64'sh80000000, 0);
        add_point(10000, 70000, 0);
        add_point(50000, 50000, 1);
        add_point(-5, 100, 0);
        add_point(100, 100, 0);
        add_point(100, 65537, 1);
        add_point(70000, 70000, 0);
        add_point(-70000, -70000, 1);
        add_point(32768, 32767, 0);
        add_point(-1, 32768, 1);
        wait_idle();

        // full-range box, extreme spans
        apply_cfg(-64'sh80000000, 64'sh7FFFFFFF, -64'sh80000000, 64'sh7FFFFFFF, 8191, 0);
        add_curves(40);
        wait_idle();

        // empty span on x
        apply_cfg(1000, 1000, -50000, 50000, 8191, 8191);
        add_curves(30);
        wait_idle();

        // inverted bounds: nothing inside
        apply_cfg(50000, -50000, 60000, 0, 300, 700);
        add_curves(20);
        wait_idle();

        set_mode();
        random_cfg();
        add_curves(60);
        hold_req = hold_req + 1;
        wait_idle();

        while (n_points < 460) begin
            set_mode();
            random_cfg();
            add_curves(50);
            wait_idle();
        end

        $display("%0d points over %0d register settings, %0d vertices and %0d end markers",
                 n_points, n_settings, n_vertices, n_markers);
        $display("box extremes, empty and inverted spans, long output stall covered");
        if (err_cnt == 0 && vertex_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches, %0d results outstanding", err_cnt, vertex_q.size());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
